/* hw/rtl/onew_pkg.sv */
package onew_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_SETTLE_A = 4'd1,
    PH_RST_LOW  = 4'd2,
    PH_PWAIT    = 4'd3,
    PH_SETTLE_B = 4'd4,
    PH_WLOW     = 4'd5,
    PH_WREC     = 4'd6,
    PH_RLOW     = 4'd7,
    PH_RWAIT    = 4'd8,
    PH_RREC     = 4'd9
  } phase_t;

  localparam logic [2:0] OP_RESET      = 3'd0;
  localparam logic [2:0] OP_WRITE_BYTE = 3'd1;
  localparam logic [2:0] OP_READ_BYTE  = 3'd2;
  localparam logic [2:0] OP_WRITE_BIT  = 3'd3;
  localparam logic [2:0] OP_READ_BIT   = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESET_LOW     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESENCE_WAIT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WRITE_ONE_LOW = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WRITE_ZERO    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RECOVERY      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_READ_LOW      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_READ_SAMPLE   = 3'd7;

  localparam phase_t RST_SEQ [4] = '{PH_SETTLE_A, PH_RST_LOW, PH_PWAIT, PH_SETTLE_B};
  localparam phase_t WR_SEQ  [2] = '{PH_WLOW, PH_WREC};
  localparam phase_t RD_SEQ  [3] = '{PH_RLOW, PH_RWAIT, PH_RREC};

  typedef struct packed {
    logic [9:0] settle_us;
    logic [9:0] reset_low_us;
    logic [9:0] presence_wait_us;
    logic [9:0] write_one_low_us;
    logic [9:0] write_zero_low_us;
    logic [9:0] recovery_us;
    logic [9:0] read_low_us;
    logic [9:0] read_sample_us;
  } cfg_t;

  typedef struct packed {
    logic       start_req;
    logic [2:0] operation;
    logic [7:0] data;
    logic       line_sample;
  } item_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       presence;
    logic [7:0] read_data;
  } res_t;

endpackage

/* hw/rtl/onew_in_if.sv */
interface onew_in_if;
  logic       valid;
  logic       ready;
  logic       start_req;
  logic [2:0] operation;
  logic [7:0] data;
  logic       line_sample;

  modport source (output valid, start_req, operation, data, line_sample, input ready);
  modport sink   (input valid, start_req, operation, data, line_sample, output ready);
endinterface

/* hw/rtl/onew_out_if.sv */
interface onew_out_if;
  logic       valid;
  logic       ready;
  logic       drive_low;
  logic       busy_res;
  logic       done_res;
  logic       presence;
  logic [7:0] read_data;

  modport source (output valid, drive_low, busy_res, done_res, presence, read_data,
                  input ready);
  modport sink   (input valid, drive_low, busy_res, done_res, presence, read_data,
                  output ready);
endinterface

/* hw/rtl/onew_cfg.sv */
module onew_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           we,
  input  logic [onew_pkg::CFG_IDX_W-1:0]  idx,
  input  logic [onew_pkg::CFG_DATA_W-1:0] wdata,
  output onew_pkg::cfg_t                 cfg
);
  import onew_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (we) begin
      case (idx)
        CFG_SETTLE:        cfg_nxt.settle_us         = wdata;
        CFG_RESET_LOW:     cfg_nxt.reset_low_us      = wdata;
        CFG_PRESENCE_WAIT: cfg_nxt.presence_wait_us  = wdata;
        CFG_WRITE_ONE_LOW: cfg_nxt.write_one_low_us  = wdata;
        CFG_WRITE_ZERO:    cfg_nxt.write_zero_low_us = wdata;
        CFG_RECOVERY:      cfg_nxt.recovery_us       = wdata;
        CFG_READ_LOW:      cfg_nxt.read_low_us       = wdata;
        CFG_READ_SAMPLE:   cfg_nxt.read_sample_us    = wdata;
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.settle_us         <= 10'd10;
      cfg_r.reset_low_us      <= 10'd500;
      cfg_r.presence_wait_us  <= 10'd20;
      cfg_r.write_one_low_us  <= 10'd10;
      cfg_r.write_zero_low_us <= 10'd80;
      cfg_r.recovery_us       <= 10'd10;
      cfg_r.read_low_us       <= 10'd2;
      cfg_r.read_sample_us    <= 10'd10;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* hw/rtl/onew_engine.sv */
module onew_engine #(
  parameter int COUNT_WIDTH = 10
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step,
  input  onew_pkg::item_t item,
  input  onew_pkg::cfg_t  cfg,
  output onew_pkg::res_t  res
);
  import onew_pkg::*;

  function automatic logic [COUNT_WIDTH-1:0] len_of(phase_t q, logic b0, cfg_t c);
    logic [COUNT_WIDTH-1:0] v;
    case (q)
      PH_SETTLE_A, PH_SETTLE_B: v = COUNT_WIDTH'(c.settle_us);
      PH_RST_LOW:               v = COUNT_WIDTH'(c.reset_low_us);
      PH_PWAIT:                 v = COUNT_WIDTH'(c.presence_wait_us);
      PH_WLOW:                  v = b0 ? COUNT_WIDTH'(c.write_one_low_us)
                                       : COUNT_WIDTH'(c.write_zero_low_us);
      PH_WREC, PH_RREC:         v = COUNT_WIDTH'(c.recovery_us);
      PH_RLOW:                  v = COUNT_WIDTH'(c.read_low_us);
      default:                  v = COUNT_WIDTH'(c.read_sample_us);
    endcase
    return v;
  endfunction

  function automatic logic is_low_phase(phase_t q);
    return (q == PH_RST_LOW) || (q == PH_WLOW) || (q == PH_RLOW);
  endfunction

  phase_t                 phase_r, phase_nxt;
  logic [COUNT_WIDTH-1:0] tick_count_r, tick_count_nxt;
  logic [3:0]             bit_index_r, bit_index_nxt;
  logic [7:0]             shift_reg_r, shift_reg_nxt;
  logic [2:0]             current_op_r, current_op_nxt;
  logic                   presence_r, presence_nxt;
  logic [7:0]             last_read_r, last_read_nxt;

  logic                   drv;
  logic                   done;
  logic                   go;
  logic                   stopq;
  logic                   found;
  logic [COUNT_WIDTH-1:0] lenq;
  logic [3:0]             nbits;
  logic [3:0]             b1;
  logic [3:0]             rem;
  logic [2:0]             k_sel;
  logic [7:0]             s1;
  logic [7:0]             fill;

  always_comb begin
    phase_nxt      = phase_r;
    tick_count_nxt = tick_count_r;
    bit_index_nxt  = bit_index_r;
    shift_reg_nxt  = shift_reg_r;
    current_op_nxt = current_op_r;
    presence_nxt   = presence_r;
    last_read_nxt  = last_read_r;
    drv   = 1'b0;
    done  = 1'b0;
    go    = 1'b0;
    stopq = 1'b0;
    found = 1'b0;
    lenq  = '0;
    b1    = '0;
    rem   = '0;
    k_sel = '0;
    s1    = '0;
    fill  = '0;

    if (phase_r == PH_IDLE && item.start_req && item.operation <= OP_READ_BIT) begin
      current_op_nxt = item.operation;
      shift_reg_nxt  = item.data;
      bit_index_nxt  = '0;
      tick_count_nxt = '0;
      case (item.operation)
        OP_RESET:                   phase_nxt = PH_SETTLE_A;
        OP_WRITE_BYTE, OP_WRITE_BIT: phase_nxt = PH_WLOW;
        default:                    phase_nxt = PH_RLOW;
      endcase
    end

    nbits = (current_op_nxt == OP_WRITE_BYTE || current_op_nxt == OP_READ_BYTE) ? 4'd8 : 4'd1;

    case (phase_nxt)
      PH_SETTLE_A, PH_RST_LOW, PH_PWAIT, PH_SETTLE_B: begin
        go = 1'b1;
        for (int i = 0; i < 4; i++) begin
          if (go && RST_SEQ[i] >= phase_nxt) begin
            lenq  = len_of(RST_SEQ[i], 1'b0, cfg);
            stopq = (RST_SEQ[i] == phase_nxt) ? (tick_count_nxt < lenq) : (lenq != '0);
            if (stopq) begin
              tick_count_nxt = ((RST_SEQ[i] == phase_nxt) ? tick_count_nxt : '0) + 1'b1;
              drv       = is_low_phase(RST_SEQ[i]);
              phase_nxt = RST_SEQ[i];
              go        = 1'b0;
            end else if (RST_SEQ[i] == PH_PWAIT) begin
              presence_nxt = ~item.line_sample;
            end
          end
        end
        if (go) begin
          phase_nxt      = PH_IDLE;
          tick_count_nxt = '0;
          done           = 1'b1;
        end
      end

      PH_WLOW, PH_WREC: begin
        go = 1'b1;
        for (int i = 0; i < 2; i++) begin
          if (go && WR_SEQ[i] >= phase_nxt) begin
            lenq  = len_of(WR_SEQ[i], shift_reg_nxt[0], cfg);
            stopq = (WR_SEQ[i] == phase_nxt) ? (tick_count_nxt < lenq) : (lenq != '0);
            if (stopq) begin
              tick_count_nxt = ((WR_SEQ[i] == phase_nxt) ? tick_count_nxt : '0) + 1'b1;
              drv       = is_low_phase(WR_SEQ[i]);
              phase_nxt = WR_SEQ[i];
              go        = 1'b0;
            end
          end
        end
        if (go) begin
          b1 = bit_index_nxt + 4'd1;
          s1 = shift_reg_nxt >> 1;
          if (b1 >= nbits) begin
            bit_index_nxt  = b1;
            shift_reg_nxt  = s1;
            phase_nxt      = PH_IDLE;
            tick_count_nxt = '0;
            done           = 1'b1;
          end else begin
            rem = nbits - b1;
            // Slots whose low time and recovery are both zero pass within this tick.
            for (int k = 0; k < 8; k++) begin
              if (!found && 4'(k) < rem &&
                  (len_of(PH_WREC, 1'b0, cfg) != '0 || len_of(PH_WLOW, s1[k], cfg) != '0)) begin
                found = 1'b1;
                k_sel = 3'(k);
              end
            end
            if (found) begin
              bit_index_nxt  = b1 + {1'b0, k_sel};
              shift_reg_nxt  = s1 >> k_sel;
              tick_count_nxt = COUNT_WIDTH'(1);
              if (len_of(PH_WLOW, shift_reg_nxt[0], cfg) != '0) begin
                phase_nxt = PH_WLOW;
                drv       = 1'b1;
              end else begin
                phase_nxt = PH_WREC;
              end
            end else begin
              bit_index_nxt  = nbits;
              shift_reg_nxt  = s1 >> rem;
              phase_nxt      = PH_IDLE;
              tick_count_nxt = '0;
              done           = 1'b1;
            end
          end
        end
      end

      PH_RLOW, PH_RWAIT, PH_RREC: begin
        go = 1'b1;
        for (int i = 0; i < 3; i++) begin
          if (go && RD_SEQ[i] >= phase_nxt) begin
            lenq  = len_of(RD_SEQ[i], 1'b0, cfg);
            stopq = (RD_SEQ[i] == phase_nxt) ? (tick_count_nxt < lenq) : (lenq != '0);
            if (stopq) begin
              tick_count_nxt = ((RD_SEQ[i] == phase_nxt) ? tick_count_nxt : '0) + 1'b1;
              drv       = is_low_phase(RD_SEQ[i]);
              phase_nxt = RD_SEQ[i];
              go        = 1'b0;
            end else if (RD_SEQ[i] == PH_RWAIT) begin
              shift_reg_nxt = {item.line_sample, shift_reg_nxt[7:1]};
            end
          end
        end
        if (go) begin
          b1 = bit_index_nxt + 4'd1;
          if (b1 >= nbits) begin
            bit_index_nxt  = b1;
            last_read_nxt  = (current_op_nxt == OP_READ_BIT) ? {7'd0, shift_reg_nxt[7]}
                                                             : shift_reg_nxt;
            phase_nxt      = PH_IDLE;
            tick_count_nxt = '0;
            done           = 1'b1;
          end else if (len_of(PH_RLOW, 1'b0, cfg) != '0 ||
                       len_of(PH_RWAIT, 1'b0, cfg) != '0 ||
                       len_of(PH_RREC, 1'b0, cfg) != '0) begin
            bit_index_nxt  = b1;
            tick_count_nxt = COUNT_WIDTH'(1);
            if (len_of(PH_RLOW, 1'b0, cfg) != '0) begin
              phase_nxt = PH_RLOW;
              drv       = 1'b1;
            end else if (len_of(PH_RWAIT, 1'b0, cfg) != '0) begin
              phase_nxt = PH_RWAIT;
            end else begin
              shift_reg_nxt = {item.line_sample, shift_reg_nxt[7:1]};
              phase_nxt     = PH_RREC;
            end
          end else begin
            // An all-zero read slot repeats for every remaining bit on the same line level.
            rem            = nbits - b1;
            fill           = item.line_sample ? ~(8'hFF >> rem) : 8'h00;
            shift_reg_nxt  = (shift_reg_nxt >> rem) | fill;
            last_read_nxt  = shift_reg_nxt;
            bit_index_nxt  = nbits;
            phase_nxt      = PH_IDLE;
            tick_count_nxt = '0;
            done           = 1'b1;
          end
        end
      end

      default: begin
        drv = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      tick_count_r <= '0;
      bit_index_r  <= '0;
      shift_reg_r  <= '0;
      current_op_r <= '0;
      presence_r   <= 1'b0;
      last_read_r  <= '0;
    end else if (step) begin
      phase_r      <= phase_nxt;
      tick_count_r <= tick_count_nxt;
      bit_index_r  <= bit_index_nxt;
      shift_reg_r  <= shift_reg_nxt;
      current_op_r <= current_op_nxt;
      presence_r   <= presence_nxt;
      last_read_r  <= last_read_nxt;
    end
  end

  assign res.drive_low = drv;
  assign res.busy_res  = (phase_nxt != PH_IDLE);
  assign res.done_res  = done;
  assign res.presence  = presence_nxt;
  assign res.read_data = last_read_nxt;

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.done_res |-> !res.busy_res)
    else $error("done reported while a command still runs");

  a_idle_released: assert property (@(posedge clk) disable iff (!rst_n)
    step && !res.busy_res |-> !res.drive_low)
    else $error("bus driven low while idle");

  a_idle_count_clear: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_IDLE |-> tick_count_r == '0)
    else $error("tick counter left nonzero in idle");

  a_bit_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> bit_index_r <= 4'd8)
    else $error("bit index ran past a byte");

endmodule

/* hw/rtl/one_wire_bus_master.sv */
// An input beat is held in the input register; the phase state updates and the result
// register loads as the beat leaves, which waits until any held result is taken.
// Throughput: one tick beat per cycle unless the output stalls; the input and result
// registers form a two-stage pipeline.
// Reset: synchronous active-low rst_n idles the engine, clears the valid flags and
// engine state and loads the default slot timings into the configuration registers.
module one_wire_bus_master #(
  parameter int COUNT_WIDTH = 10
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [onew_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [onew_pkg::CFG_DATA_W-1:0] cfg_wdata,
  onew_in_if.sink                        in_bus,
  onew_out_if.source                     out_bus
);
  import onew_pkg::*;

  cfg_t  cfg;
  res_t  res;

  logic  s1_valid_r, s1_valid_nxt;
  item_t s1_item_r;
  logic  out_valid_r, out_valid_nxt;
  res_t  out_res_r;
  logic  adv;
  logic  in_fire;

  assign adv     = s1_valid_r && (!out_valid_r || out_bus.ready);
  assign in_fire = in_bus.valid && in_bus.ready;
  assign in_bus.ready = !s1_valid_r || adv;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r <= {in_bus.start_req, in_bus.operation, in_bus.data, in_bus.line_sample};
    end
    if (adv) begin
      out_res_r <= res;
    end
  end

  onew_cfg u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (cfg_we),
    .idx   (cfg_idx),
    .wdata (cfg_wdata),
    .cfg   (cfg)
  );

  onew_engine #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (adv),
    .item  (s1_item_r),
    .cfg   (cfg),
    .res   (res)
  );

  assign out_bus.valid     = out_valid_r;
  assign out_bus.drive_low = out_res_r.drive_low;
  assign out_bus.busy_res  = out_res_r.busy_res;
  assign out_bus.done_res  = out_res_r.done_res;
  assign out_bus.presence  = out_res_r.presence;
  assign out_bus.read_data = out_res_r.read_data;

endmodule
